// File: hdl/mlp_pkg.sv
// Package for the two-layer perceptron block: sizes, word types, sequencer
// states and the fixed-point rounding and sigmoid helpers.
// No dependencies.
`default_nettype none

package mlp_pkg;

    // Network dimensions.
    localparam int MAX_INPUTS  = 8;
    localparam int MAX_HIDDEN  = 16;
    localparam int MAX_OUTPUTS = 4;

    // Weight table depths and address widths.
    localparam int L1_DEPTH = (MAX_INPUTS + 1) * MAX_HIDDEN;
    localparam int L2_DEPTH = (MAX_HIDDEN + 1) * MAX_OUTPUTS;
    localparam int L1_AW    = $clog2(L1_DEPTH);
    localparam int L2_AW    = $clog2(L2_DEPTH);

    // Counter and index widths.
    localparam int NEURON_W = $clog2(MAX_HIDDEN);
    localparam int TERM_W   = $clog2(MAX_HIDDEN + 1);
    localparam int FEAT_IW  = $clog2(MAX_INPUTS);
    localparam int HID_IW   = $clog2(MAX_HIDDEN);

    // Field and register widths.
    localparam int ADDR_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int ACT_W    = 13;
    localparam int OIDX_W   = 2;
    localparam int NI_W     = 4;
    localparam int NH_W     = 5;
    localparam int NO_W     = 3;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 5;

    // Arithmetic widths: 16x17 products, exact neuron sums.
    localparam int OPND_W   = 17;
    localparam int PROD_W   = VALUE_W + OPND_W;
    localparam int ACC_W    = 36;

    // Register reset values.
    localparam logic [NI_W-1:0] NI_RESET = NI_W'(2);
    localparam logic [NH_W-1:0] NH_RESET = NH_W'(3);
    localparam logic [NO_W-1:0] NO_RESET = NO_W'(1);

    // Configuration register indexes.
    typedef enum logic [CFG_IW-1:0] {
        CFG_INPUTS  = 2'd0,
        CFG_HIDDEN  = 2'd1,
        CFG_OUTPUTS = 2'd2,
        CFG_SPARE   = 2'd3
    } cfg_reg_t;

    // Item modes.
    localparam logic MODE_WEIGHT  = 1'b0;
    localparam logic MODE_FEATURE = 1'b1;

    // Input word.
    typedef struct packed {
        logic                       mode;
        logic [ADDR_W-1:0]          weight_address;
        logic signed [VALUE_W-1:0]  value;
        logic                       last_feature;
    } in_item_t;

    // Result word.
    typedef struct packed {
        logic [OIDX_W-1:0] output_index;
        logic [ACT_W-1:0]  activation;
        logic              last_output;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LAYER1,
        S_DRAIN,
        S_LAYER2,
        S_FINISH
    } state_t;

    // Tag that travels with each term through the MAC pipeline.
    typedef struct packed {
        logic                first;
        logic                last;
        logic                layer2;
        logic [NEURON_W-1:0] neuron;
    } tag_t;

    // Round a Q.24 sum to Q.12 (add half, floor) and saturate to 16 bits.
    function automatic logic signed [VALUE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] sum
    );
        logic signed [ACC_W:0]    q;
        logic        [ACC_W-12:0] r;
        logic signed [VALUE_W-1:0] res;
        q = {sum[ACC_W-1], sum} + (ACC_W + 1)'(2048);
        r = q[ACC_W:12];
        if ((&r[ACC_W-12:VALUE_W-1]) || !(|r[ACC_W-12:VALUE_W-1])) begin
            res = r[VALUE_W-1:0];
        end else if (r[ACC_W-12]) begin
            res = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Piecewise-linear sigmoid, Q4.12 in, unsigned Q1.12 out.
    function automatic logic [ACT_W-1:0] sigmoid(
        input logic signed [VALUE_W-1:0] x
    );
        logic [VALUE_W-1:0] a;
        logic [ACT_W-1:0]   y;
        a = x[VALUE_W-1] ? VALUE_W'(-x) : x;
        if (a < VALUE_W'(4096)) begin
            y = ACT_W'(a >> 2) + ACT_W'(2048);
        end else if (a < VALUE_W'(9728)) begin
            y = ACT_W'(a >> 3) + ACT_W'(2560);
        end else if (a < VALUE_W'(20480)) begin
            y = ACT_W'(a >> 5) + ACT_W'(3456);
        end else begin
            y = ACT_W'(4096);
        end
        if (x[VALUE_W-1]) begin
            y = ACT_W'(4096) - y;
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mlp_two_layer_sigmoid_inference.sv
// Two-layer sigmoid perceptron: weight tables, feature buffer, one shared
// multiply-accumulate unit under a small sequencer.
// Depends on mlp_pkg.
//
// Weight words and feature words other than the last one are taken while
// busy is low, and busy stays low. A feature word with last_feature set
// starts a forward pass and holds busy high until its last result is out:
// every bias and weight of the inputs, hidden neurons and outputs in use
// goes once through the single multiplier, one term per cycle, and the
// pass pauses for the pipeline to empty between the layers and at the
// end. Results come out one per output in use, in index order, each on
// result for exactly one cycle with result_valid high; the receiver cannot
// stall them. Configuration writes are always ready and must only be
// issued while busy is low.
`default_nettype none

module mlp_two_layer_sigmoid_inference (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire mlp_pkg::in_item_t             item,
    output logic                               result_valid,
    output mlp_pkg::out_item_t                 result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mlp_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [mlp_pkg::CFG_DW-1:0]    cfg_data
);
    import mlp_pkg::*;

    // Configuration registers, raw bits kept.
    logic [NI_W-1:0] ni_raw_reg;
    logic [NH_W-1:0] nh_raw_reg;
    logic [NO_W-1:0] no_raw_reg;
    logic [NI_W-1:0] ni_eff;
    logic [NH_W-1:0] nh_eff;
    logic [NO_W-1:0] no_eff;

    // Storage.
    logic [VALUE_W-1:0] l1_mem [L1_DEPTH];
    logic [VALUE_W-1:0] l2_mem [L2_DEPTH];
    logic [VALUE_W-1:0] feature_store_reg [MAX_INPUTS];
    logic [ACT_W-1:0]   hidden_store_reg [MAX_HIDDEN];
    logic [NI_W-1:0]    feature_count_reg;

    // Sequencer.
    state_t              state_reg, state_next;
    logic [TERM_W-1:0]   term_reg, term_next;
    logic [NEURON_W-1:0] neuron_reg, neuron_next;
    logic                issue;
    logic                is_layer2;
    logic                last_term;
    logic                last_neuron;
    logic                pipe_empty;
    logic                pass_start;
    logic                pass_end;
    logic                accept;

    // Issue stage.
    logic [L1_AW-1:0]        l1_rd_addr;
    logic [L2_AW-1:0]        l2_rd_addr;
    logic signed [OPND_W-1:0] opnd0;
    tag_t                    tag0;

    // MAC pipeline.
    logic                     v1_reg, v2_reg, done3_reg, done4_reg;
    tag_t                     tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [VALUE_W-1:0]       l1_rdata_reg, l2_rdata_reg;
    logic signed [OPND_W-1:0] opnd1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [VALUE_W-1:0] sat_reg;
    logic signed [VALUE_W-1:0] weight1;
    logic [ACT_W-1:0]         act4;

    // Output register.
    logic      result_valid_reg;
    out_item_t result_reg;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Clamp register values to their legal ranges.
    always_comb
    begin
        ni_eff = (ni_raw_reg == '0) ? NI_W'(1) :
                 (ni_raw_reg > NI_W'(MAX_INPUTS)) ? NI_W'(MAX_INPUTS) : ni_raw_reg;
        nh_eff = (nh_raw_reg == '0) ? NH_W'(1) :
                 (nh_raw_reg > NH_W'(MAX_HIDDEN)) ? NH_W'(MAX_HIDDEN) : nh_raw_reg;
        no_eff = (no_raw_reg == '0) ? NO_W'(1) :
                 (no_raw_reg > NO_W'(MAX_OUTPUTS)) ? NO_W'(MAX_OUTPUTS) : no_raw_reg;
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ni_raw_reg <= NI_RESET;
            nh_raw_reg <= NH_RESET;
            no_raw_reg <= NO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_INPUTS:  ni_raw_reg <= cfg_data[NI_W-1:0];
                CFG_HIDDEN:  nh_raw_reg <= cfg_data[NH_W-1:0];
                CFG_OUTPUTS: no_raw_reg <= cfg_data[NO_W-1:0];
                default:     ;
            endcase
        end
    end

    assign pipe_empty  = !v1_reg && !v2_reg && !done3_reg && !done4_reg;
    assign is_layer2   = (state_reg == S_LAYER2);
    assign issue       = (state_reg == S_LAYER1) || is_layer2;
    assign last_term   = is_layer2 ? (term_reg == TERM_W'(nh_eff))
                                   : (term_reg == TERM_W'(ni_eff));
    assign last_neuron = is_layer2 ? ((NH_W)'(neuron_reg) == NH_W'(no_eff) - NH_W'(1))
                                   : ((NH_W)'(neuron_reg) == nh_eff - NH_W'(1));
    assign pass_start  = accept && (item.mode == MODE_FEATURE) && item.last_feature;

    // Sequencer: next state and term/neuron counters.
    always_comb
    begin
        state_next  = state_reg;
        term_next   = term_reg;
        neuron_next = neuron_reg;
        pass_end    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                term_next   = '0;
                neuron_next = '0;
                if (pass_start)
                begin
                    state_next = S_LAYER1;
                end
            end
            S_LAYER1, S_LAYER2:
            begin
                if (last_term)
                begin
                    term_next   = '0;
                    neuron_next = neuron_reg + NEURON_W'(1);
                    if (last_neuron)
                    begin
                        neuron_next = '0;
                        state_next  = is_layer2 ? S_FINISH : S_DRAIN;
                    end
                end
                else
                begin
                    term_next = term_reg + TERM_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = S_LAYER2;
                end
            end
            S_FINISH:
            begin
                if (pipe_empty)
                begin
                    state_next = S_IDLE;
                    pass_end   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            term_reg   <= '0;
            neuron_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            term_reg   <= term_next;
            neuron_reg <= neuron_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Feature count: advances on stored features, clears after a pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_count_reg <= '0;
        end
        else if (pass_end)
        begin
            feature_count_reg <= '0;
        end
        else if (accept && (item.mode == MODE_FEATURE) && (feature_count_reg < ni_eff))
        begin
            feature_count_reg <= feature_count_reg + NI_W'(1);
        end
    end

    // Feature buffer writes.
    always_ff @(posedge clk)
    begin
        if (accept && (item.mode == MODE_FEATURE) && (feature_count_reg < ni_eff))
        begin
            feature_store_reg[FEAT_IW'(feature_count_reg)] <= item.value;
        end
    end

    // Weight tables: written by weight words, read once per issued term.
    always_ff @(posedge clk)
    begin
        if (accept && (item.mode == MODE_WEIGHT))
        begin
            if (item.weight_address < ADDR_W'(L1_DEPTH))
            begin
                l1_mem[L1_AW'(item.weight_address)] <= item.value;
            end
            else if (item.weight_address < ADDR_W'(L1_DEPTH + L2_DEPTH))
            begin
                l2_mem[L2_AW'(item.weight_address - ADDR_W'(L1_DEPTH))] <= item.value;
            end
        end
        l1_rdata_reg <= l1_mem[l1_rd_addr];
        l2_rdata_reg <= l2_mem[l2_rd_addr];
    end

    // Issue stage: weight address, multiplier operand and term tag.
    always_comb
    begin
        l1_rd_addr = L1_AW'(int'(term_reg) * MAX_HIDDEN + int'(neuron_reg));
        l2_rd_addr = L2_AW'(int'(term_reg) * MAX_OUTPUTS + int'(neuron_reg));
        if (term_reg == '0)
        begin
            opnd0 = OPND_W'(4096);
        end
        else if (is_layer2)
        begin
            opnd0 = {{(OPND_W-ACT_W){1'b0}}, hidden_store_reg[HID_IW'(term_reg - TERM_W'(1))]};
        end
        else if (term_reg <= TERM_W'(feature_count_reg))
        begin
            opnd0 = {{(OPND_W-VALUE_W){feature_store_reg[FEAT_IW'(term_reg - TERM_W'(1))]
                      [VALUE_W-1]}},
                     feature_store_reg[FEAT_IW'(term_reg - TERM_W'(1))]};
        end
        else
        begin
            opnd0 = '0;
        end
        tag0.first  = (term_reg == '0);
        tag0.last   = last_term;
        tag0.layer2 = is_layer2;
        tag0.neuron = neuron_reg;
    end

    // Pipeline control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            done3_reg        <= 1'b0;
            done4_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg           <= issue;
            v2_reg           <= v1_reg;
            done3_reg        <= v2_reg && tag2_reg.last;
            done4_reg        <= done3_reg;
            result_valid_reg <= done4_reg && tag4_reg.layer2;
        end
    end

    assign weight1 = tag1_reg.layer2 ? l2_rdata_reg : l1_rdata_reg;

    // Multiply, accumulate, round and saturate.
    always_ff @(posedge clk)
    begin
        tag1_reg  <= tag0;
        opnd1_reg <= opnd0;
        tag2_reg  <= tag1_reg;
        prod_reg  <= weight1 * opnd1_reg;
        if (v2_reg)
        begin
            acc_reg  <= (tag2_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
            tag3_reg <= tag2_reg;
        end
        sat_reg  <= round_sat(acc_reg);
        tag4_reg <= tag3_reg;
    end

    assign act4 = sigmoid(sat_reg);

    // Hidden values and result word.
    always_ff @(posedge clk)
    begin
        if (done4_reg && !tag4_reg.layer2)
        begin
            hidden_store_reg[HID_IW'(tag4_reg.neuron)] <= act4;
        end
        result_reg.output_index <= OIDX_W'(tag4_reg.neuron);
        result_reg.activation   <= act4;
        result_reg.last_output  <= (NH_W'(tag4_reg.neuron) == NH_W'(no_eff) - NH_W'(1));
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result only appears during a pass.
    a_result_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a pass");

    // The final result of a pass is followed by idle.
    a_last_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_output) |=> !busy)
        else $error("pass did not end after its final result");

    // Output indexes stay inside the outputs in use.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (NO_W'(result.output_index) < no_eff))
        else $error("result index beyond outputs in use");

    // The MAC pipeline is empty whenever the block is idle.
    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (!v1_reg && !v2_reg && !done3_reg && !done4_reg))
        else $error("MAC pipeline active while idle");

    // Layer two never starts before all hidden values are written.
    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == S_DRAIN && state_reg == S_LAYER2) |-> $past(pipe_empty))
        else $error("layer two started with hidden values in flight");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the two-layer sigmoid perceptron block.
// Drives weight and feature words, predicts every activation in fixed point
// and checks each result word; depends on mlp_pkg and the block itself.
`timescale 1ns / 100ps

module testbench;

    import mlp_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_GUARD    = 5000;
    localparam int RANDOM_WORDS  = 175;

    typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

    // One row of the directed script: a word to send or a register to write.
    typedef struct {
        row_kind_t   kind;
        cfg_reg_t    reg_sel;
        logic [4:0]  reg_data;
        in_item_t    word;
        bit          typed;
        logic [12:0] act;
    } step_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    in_item_t        item;
    logic            result_valid;
    out_item_t       result;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    // Predictor state: weight tables, feature buffer and hidden activations.
    logic signed [15:0] w_hidden [L1_DEPTH];
    logic signed [15:0] w_out [L2_DEPTH];
    logic signed [15:0] feat_buf [MAX_INPUTS];
    logic [12:0]        hid_act [MAX_HIDDEN];
    int                 feat_fill;
    logic [NI_W-1:0]    raw_inputs;
    logic [NH_W-1:0]    raw_hidden;
    logic [NO_W-1:0]    raw_outputs;

    // Activations predicted but not yet seen on the result port.
    out_item_t pending_outputs [$];

    int    fail_count;
    step_t script [32];
    int    script_len;
    int    burst_left;
    int    random_sent;

    mlp_two_layer_sigmoid_inference u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Safety net in case the block stops answering.
    initial
    begin
        #6_000_000;
        $display("mlp_two_layer_sigmoid_inference verification failed");
        $finish;
    end

    function automatic void note_failure(input string msg);
        if (fail_count < 10)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    function automatic int clamp_count(input int v, input int hi);
        if (v < 1)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // Round a Q.24 sum to Q.12 (add half, floor) and saturate to 16 bits.
    function automatic int round_q12(input longint s);
        longint q;
        q = (s + 2048) >>> 12;
        if (q > 32767)
        begin
            q = 32767;
        end
        if (q < -32768)
        begin
            q = -32768;
        end
        return int'(q);
    endfunction

    // Piecewise-linear sigmoid on a Q4.12 value, giving unsigned Q1.12.
    function automatic logic [12:0] squash(input int x);
        int a;
        int y;
        a = (x < 0) ? -x : x;
        if (a < 4096)
        begin
            y = (a >> 2) + 2048;
        end
        else if (a < 9728)
        begin
            y = (a >> 3) + 2560;
        end
        else if (a < 20480)
        begin
            y = (a >> 5) + 3456;
        end
        else
        begin
            y = 4096;
        end
        if (x < 0)
        begin
            y = 4096 - y;
        end
        return y[12:0];
    endfunction

    function automatic void store_reg(input cfg_reg_t idx, input logic [4:0] data);
        case (idx)
            CFG_INPUTS:  raw_inputs  = data[NI_W-1:0];
            CFG_HIDDEN:  raw_hidden  = data[NH_W-1:0];
            CFG_OUTPUTS: raw_outputs = data[NO_W-1:0];
            default:     ;
        endcase
    endfunction

    // Update the predictor with one accepted word and queue the activations
    // it causes. A typed activation replaces the computed one.
    function automatic void apply_word(input in_item_t w, input bit typed,
                                       input logic [12:0] act);
        int        ni;
        int        nh;
        int        no;
        int        h;
        int        j;
        int        k;
        longint    acc;
        longint    f;
        out_item_t r;
        ni = clamp_count(int'(raw_inputs), MAX_INPUTS);
        nh = clamp_count(int'(raw_hidden), MAX_HIDDEN);
        no = clamp_count(int'(raw_outputs), MAX_OUTPUTS);
        if (w.mode == MODE_WEIGHT)
        begin
            if (int'(w.weight_address) < L1_DEPTH)
            begin
                w_hidden[w.weight_address] = w.value;
            end
            else if (int'(w.weight_address) < L1_DEPTH + L2_DEPTH)
            begin
                w_out[int'(w.weight_address) - L1_DEPTH] = w.value;
            end
            return;
        end
        if (feat_fill < ni)
        begin
            feat_buf[feat_fill] = w.value;
            feat_fill++;
        end
        if (!w.last_feature)
        begin
            return;
        end
        // Hidden layer: bias plus weighted features.
        for (h = 0; h < nh; h++)
        begin
            acc = longint'(w_hidden[h]) * 4096;
            for (j = 0; j < ni; j++)
            begin
                f = (j < feat_fill) ? longint'(feat_buf[j]) : 0;
                acc += longint'(w_hidden[(j + 1) * MAX_HIDDEN + h]) * f;
            end
            hid_act[h] = squash(round_q12(acc));
        end
        // Output layer: bias plus weighted hidden activations.
        for (k = 0; k < no; k++)
        begin
            acc = longint'(w_out[k]) * 4096;
            for (h = 0; h < nh; h++)
            begin
                acc += longint'(w_out[(h + 1) * MAX_OUTPUTS + k]) * longint'(hid_act[h]);
            end
            r.output_index = k[1:0];
            r.activation   = typed ? act : squash(round_q12(acc));
            r.last_output  = (k == no - 1);
            pending_outputs.push_back(r);
        end
        feat_fill = 0;
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send_word(input in_item_t w, input bit typed, input logic [12:0] act);
        @(negedge clk);
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        apply_word(w, typed, act);
    endtask

    task automatic idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic paced_send(input in_item_t w);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                idle($urandom_range(1, 6));
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        send_word(w, 1'b0, '0);
    endtask

    // Wait until every predicted result has arrived and the block is idle.
    task automatic wait_idle();
        int guard;
        guard = 0;
        @(negedge clk);
        start <= 1'b0;
        while ((pending_outputs.size() != 0 || busy) && guard < IDLE_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        if (guard >= IDLE_GUARD)
        begin
            note_failure($sformatf("%0d expected result words never arrived",
                                   pending_outputs.size()));
            pending_outputs.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [4:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        store_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void put_word(input logic mode, input logic [7:0] addr,
                                     input logic [15:0] val, input logic last,
                                     input bit typed, input logic [12:0] act);
        script[script_len].kind                = ROW_WORD;
        script[script_len].reg_sel             = CFG_INPUTS;
        script[script_len].reg_data            = '0;
        script[script_len].word.mode           = mode;
        script[script_len].word.weight_address = addr;
        script[script_len].word.value          = val;
        script[script_len].word.last_feature   = last;
        script[script_len].typed               = typed;
        script[script_len].act                 = act;
        script_len++;
    endfunction

    function automatic void put_reg(input cfg_reg_t idx, input logic [4:0] data);
        script[script_len].kind     = ROW_CFG;
        script[script_len].reg_sel  = idx;
        script[script_len].reg_data = data;
        script[script_len].word     = '0;
        script[script_len].typed    = 1'b0;
        script[script_len].act      = '0;
        script_len++;
    endfunction

    // Directed script. All weights are zero when it starts, and the
    // registers hold their reset values (two inputs, three hidden, one output).
    function automatic void build_script();
        script_len = 0;
        // Zero weights give one half.
        put_word(MODE_FEATURE, 8'd0, 16'h1000, 1'b0, 1'b0, '0);
        put_word(MODE_FEATURE, 8'd0, 16'h7FFF, 1'b1, 1'b1, 13'd2048);
        // Largest output bias; the last mark on a weight word is ignored.
        put_word(MODE_WEIGHT, 8'd144, 16'h7FFF, 1'b1, 1'b0, '0);
        // Only one feature before the last mark: the other counts as zero.
        put_word(MODE_FEATURE, 8'd0, 16'h8000, 1'b1, 1'b1, 13'd4096);
        // Most negative output bias, and an extra feature carrying the mark.
        put_word(MODE_WEIGHT, 8'd144, 16'h8000, 1'b0, 1'b0, '0);
        put_word(MODE_FEATURE, 8'd0, 16'h0800, 1'b0, 1'b0, '0);
        put_word(MODE_FEATURE, 8'd0, 16'hF800, 1'b0, 1'b0, '0);
        put_word(MODE_FEATURE, 8'd0, 16'h1234, 1'b1, 1'b1, 13'd0);
        // Addresses past the second table must not disturb the bias.
        put_word(MODE_WEIGHT, 8'd212, 16'h7FFF, 1'b0, 1'b0, '0);
        put_word(MODE_WEIGHT, 8'd255, 16'h7FFF, 1'b1, 1'b0, '0);
        put_word(MODE_FEATURE, 8'hFF, 16'h0000, 1'b1, 1'b1, 13'd0);
        // A few nonzero weights, then registers below and above their ranges.
        put_word(MODE_WEIGHT, 8'd144, 16'h0000, 1'b0, 1'b0, '0);
        put_word(MODE_WEIGHT, 8'd16, 16'h7FFF, 1'b0, 1'b0, '0);
        put_word(MODE_WEIGHT, 8'd148, 16'h8000, 1'b0, 1'b0, '0);
        put_word(MODE_WEIGHT, 8'd0, 16'h8000, 1'b0, 1'b0, '0);
        put_reg(CFG_INPUTS, 5'd0);
        put_reg(CFG_HIDDEN, 5'd31);
        put_reg(CFG_OUTPUTS, 5'd7);
        put_word(MODE_FEATURE, 8'd0, 16'h7FFF, 1'b1, 1'b0, '0);
        put_word(MODE_FEATURE, 8'd0, 16'h8000, 1'b1, 1'b0, '0);
        put_reg(CFG_INPUTS, 5'd15);
        put_reg(CFG_HIDDEN, 5'd0);
        put_reg(CFG_OUTPUTS, 5'd0);
        put_word(MODE_FEATURE, 8'd0, 16'h4000, 1'b0, 1'b0, '0);
        put_word(MODE_FEATURE, 8'd0, 16'hC000, 1'b1, 1'b0, '0);
        put_reg(CFG_SPARE, 5'd31);
    endfunction

    // Random Q4.12 value, mostly small so sums land in every sigmoid segment.
    function automatic logic [15:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 65535);
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            2, 3:    v = int'($urandom_range(0, 32767)) - 16384;
            default: v = int'($urandom_range(0, 8191)) - 4096;
        endcase
        return v[15:0];
    endfunction

    // A few weight writes followed by one feature set ending in the last mark.
    // Some sets are short or overlong.
    task automatic run_sequence(output int sent);
        int       nw;
        int       nf;
        int       ni;
        int       i;
        in_item_t w;
        ni = clamp_count(int'(raw_inputs), MAX_INPUTS);
        nw = $urandom_range(0, 5);
        for (i = 0; i < nw; i++)
        begin
            w.mode           = MODE_WEIGHT;
            w.weight_address = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(212, 255))
                                                            : 8'($urandom_range(0, 211));
            w.value          = pick_value();
            w.last_feature   = 1'($urandom_range(0, 1));
            paced_send(w);
        end
        case ($urandom_range(0, 9))
            0, 1:    nf = $urandom_range(1, ni);
            2:       nf = ni + $urandom_range(1, 3);
            default: nf = ni;
        endcase
        for (i = 0; i < nf; i++)
        begin
            w.mode           = MODE_FEATURE;
            w.weight_address = 8'($urandom_range(0, 255));
            w.value          = pick_value();
            w.last_feature   = (i == nf - 1);
            paced_send(w);
        end
        sent = nw + nf;
    endtask

    // Result checker: every result word is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid)
        begin
            if (pending_outputs.size() == 0)
            begin
                note_failure($sformatf("unexpected result word idx=%0d act=%0d last=%0d",
                                       result.output_index, result.activation,
                                       result.last_output));
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (result.output_index !== want.output_index
                    || result.activation !== want.activation
                    || result.last_output !== want.last_output)
                begin
                    note_failure($sformatf("result word: expected idx=%0d act=%0d last=%0d, got idx=%0d act=%0d last=%0d",
                                           want.output_index, want.activation,
                                           want.last_output, result.output_index,
                                           result.activation, result.last_output));
                end
            end
        end
    end

    // Main stimulus.
    initial
    begin : stimulus
        int a;
        int n;
        int phase;
        int phase_words;
        int target;
        int sent;
        in_item_t w;
        logic [4:0] ni_data;
        logic [4:0] nh_data;
        logic [4:0] no_data;

        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        fail_count  = 0;
        feat_fill   = 0;
        burst_left  = 0;
        random_sent = 0;
        raw_inputs  = NI_RESET;
        raw_hidden  = NH_RESET;
        raw_outputs = NO_RESET;
        for (a = 0; a < L1_DEPTH; a++)
        begin
            w_hidden[a] = '0;
        end
        for (a = 0; a < L2_DEPTH; a++)
        begin
            w_out[a] = '0;
        end
        for (a = 0; a < MAX_INPUTS; a++)
        begin
            feat_buf[a] = '0;
        end
        for (a = 0; a < MAX_HIDDEN; a++)
        begin
            hid_act[a] = '0;
        end
        build_script();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Clear both weight tables so no entry is ever read unwritten.
        for (a = 0; a < L1_DEPTH + L2_DEPTH; a++)
        begin
            w.mode           = MODE_WEIGHT;
            w.weight_address = 8'(a);
            w.value          = '0;
            w.last_feature   = 1'b0;
            send_word(w, 1'b0, '0);
        end

        // Directed script.
        for (n = 0; n < script_len; n++)
        begin
            if (script[n].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(script[n].reg_sel, script[n].reg_data);
            end
            else
            begin
                send_word(script[n].word, script[n].typed, script[n].act);
            end
        end

        // Random phases, each with its own register setting.
        phase = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            case (phase)
                0:
                begin
                    ni_data = 5'd8;
                    nh_data = 5'd16;
                    no_data = 5'd4;
                end
                1:
                begin
                    ni_data = 5'd1;
                    nh_data = 5'd1;
                    no_data = 5'd1;
                end
                2:
                begin
                    ni_data = 5'd0;
                    nh_data = 5'd0;
                    no_data = 5'd0;
                end
                3:
                begin
                    ni_data = 5'd15;
                    nh_data = 5'd31;
                    no_data = 5'd7;
                end
                default:
                begin
                    ni_data = 5'($urandom_range(0, 31));
                    nh_data = 5'($urandom_range(0, 31));
                    no_data = 5'($urandom_range(0, 31));
                end
            endcase
            wait_idle();
            write_reg(CFG_INPUTS, ni_data);
            write_reg(CFG_HIDDEN, nh_data);
            write_reg(CFG_OUTPUTS, no_data);
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(CFG_SPARE, 5'($urandom_range(0, 31)));
            end
            phase_words = 0;
            target = $urandom_range(30, 50);
            while (phase_words < target)
            begin
                run_sequence(sent);
                phase_words += sent;
            end
            random_sent += phase_words;
            phase++;
        end

        wait_idle();
        if (fail_count == 0)
        begin
            $display("mlp_two_layer_sigmoid_inference verification clean");
        end
        else
        begin
            $display("mlp_two_layer_sigmoid_inference verification failed");
        end
        $finish;
    end

endmodule
